@@ hdl/sliding_window_arq_sender_core_assert.svh @@
// Assertion macros used by the sender core datapath.
`ifndef SLIDING_WINDOW_ARQ_SENDER_CORE_ASSERT_SVH
`define SLIDING_WINDOW_ARQ_SENDER_CORE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define SWARQ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define SWARQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/swarq_pkg.sv @@
package swarq_pkg;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [2:0] KIND_SEND_OK  = 3'd0;
    localparam logic [2:0] KIND_SEND_REF = 3'd1;
    localparam logic [2:0] KIND_ACK_DONE = 3'd2;
    localparam logic [2:0] KIND_RETX     = 3'd3;
    localparam logic [2:0] KIND_TICK_NONE = 3'd4;

    localparam logic [1:0] CFG_INIT_SEQ  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [1:0] CFG_RETRY_LIM = 2'd2;
    localparam logic [1:0] CFG_INIT_WIN  = 2'd3;

    // Most retransmit items reported by one tick.
    localparam logic [3:0] MAX_RETX = 4'd8;

    typedef struct packed {
        logic idle;
        logic accept;
        logic send_do;
        logic ack_rd;
        logic ack_retire;
        logic ack_end;
        logic tick_init;
        logic tick_rd;
        logic tick_skip;
        logic tick_hit;
        logic tick_end;
        logic flush;
    } t_ctrl;

    typedef struct packed {
        logic [1:0] cmd;
        logic       empty;
        logic       covered;
        logic       scan_more;
        logic       qual;
        logic       pend_v;
        logic       out_free;
    } t_stat;

endpackage

@@ hdl/swarq_ctrl.sv @@
module swarq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  swarq_pkg::t_stat i_stat,
    output swarq_pkg::t_ctrl o_ctrl
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_SEND      = 10'b0000000010,
        S_ACK_RD    = 10'b0000000100,
        S_ACK_CHK   = 10'b0000001000,
        S_ACK_END   = 10'b0000010000,
        S_TICK_INIT = 10'b0000100000,
        S_TICK_RD   = 10'b0001000000,
        S_TICK_CHK  = 10'b0010000000,
        S_TICK_END  = 10'b0100000000,
        S_FLUSH     = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctrl.idle = 1'b1;
                if (i_valid) begin
                    o_ctrl.accept = 1'b1;
                    unique case (i_stat.cmd)
                        swarq_pkg::CMD_SEND: n_state = S_SEND;
                        swarq_pkg::CMD_ACK:  n_state = S_ACK_RD;
                        swarq_pkg::CMD_TICK: n_state = S_TICK_INIT;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_SEND: begin
                o_ctrl.send_do = 1'b1;
                n_state = S_FLUSH;
            end
            S_ACK_RD: begin
                if (i_stat.empty) begin
                    n_state = S_ACK_END;
                end else begin
                    o_ctrl.ack_rd = 1'b1;
                    n_state = S_ACK_CHK;
                end
            end
            S_ACK_CHK: begin
                if (i_stat.covered) begin
                    o_ctrl.ack_retire = 1'b1;
                    n_state = S_ACK_RD;
                end else begin
                    n_state = S_ACK_END;
                end
            end
            S_ACK_END: begin
                o_ctrl.ack_end = 1'b1;
                n_state = S_FLUSH;
            end
            S_TICK_INIT: begin
                o_ctrl.tick_init = 1'b1;
                n_state = S_TICK_RD;
            end
            S_TICK_RD: begin
                if (i_stat.scan_more) begin
                    o_ctrl.tick_rd = 1'b1;
                    n_state = S_TICK_CHK;
                end else begin
                    n_state = S_TICK_END;
                end
            end
            S_TICK_CHK: begin
                if (!i_stat.qual) begin
                    o_ctrl.tick_skip = 1'b1;
                    n_state = S_TICK_RD;
                end else if (!i_stat.pend_v || i_stat.out_free) begin
                    o_ctrl.tick_hit = 1'b1;
                    n_state = S_TICK_RD;
                end
            end
            S_TICK_END: begin
                o_ctrl.tick_end = 1'b1;
                n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_ctrl.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ hdl/swarq_datapath.sv @@
`include "sliding_window_arq_sender_core_assert.svh"

module swarq_datapath #(
    parameter int WINDOW_SLOTS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  swarq_pkg::t_ctrl i_ctrl,
    output swarq_pkg::t_stat o_stat,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [31:0]      i_cfg_data,
    input  logic [1:0]       i_command,
    input  logic [31:0]      i_packet_seq,
    input  logic [15:0]      i_packet_len,
    input  logic [31:0]      i_ack_number,
    input  logic [15:0]      i_peer_window,
    input  logic             i_stall,
    output logic             o_valid,
    output logic [2:0]       o_kind,
    output logic [2:0]       o_slot,
    output logic [31:0]      o_out_seq,
    output logic [15:0]      o_out_len,
    output logic             o_credit_ok,
    output logic [31:0]      o_unacked_bytes,
    output logic [31:0]      o_acked_upto,
    output logic [15:0]      o_window_now,
    output logic             o_outstanding,
    output logic [3:0]       o_retries_done,
    output logic             o_last
);

    localparam int CW = $clog2(2 * WINDOW_SLOTS);
    localparam int SW = $clog2(WINDOW_SLOTS);
    localparam logic [CW-1:0] WC   = CW'(WINDOW_SLOTS);
    localparam logic [CW-1:0] CMAX = CW'(2 * WINDOW_SLOTS - 1);
    localparam logic [CW:0]   MOD2 = (CW + 1)'(2 * WINDOW_SLOTS);

    logic [15:0] r_cfg_to;
    logic [3:0]  r_cfg_lim;

    logic [31:0]   r_sent, r_acked, r_clk;
    logic [15:0]   r_win;
    logic [CW-1:0] r_base, r_next, r_idx;
    logic [3:0]    r_n;

    logic [1:0]  r_cmd;
    logic [31:0] r_pseq, r_ack;
    logic [15:0] r_plen, r_pwin;

    logic          r_pend_v;
    logic [2:0]    r_pend_kind;
    logic [SW-1:0] r_pend_slot;
    logic [31:0]   r_pend_seq;
    logic [15:0]   r_pend_len;
    logic [3:0]    r_pend_ret;
    logic          r_pend_credit;

    logic [31:0] mem_seq   [WINDOW_SLOTS];
    logic [15:0] mem_len   [WINDOW_SLOTS];
    logic [31:0] mem_stamp [WINDOW_SLOTS];
    logic [3:0]  mem_ret   [WINDOW_SLOTS];

    logic [31:0]   r_rd_seq, r_rd_stamp;
    logic [15:0]   r_rd_len;
    logic [3:0]    r_rd_ret;
    logic [SW-1:0] r_rd_slot;

    logic [CW:0]   inuse_w;
    logic [CW-1:0] inuse;
    logic          full, empty;
    logic [31:0]   unacked;
    logic          credit_now;
    logic [CW-1:0] base_c, next_c;
    logic [SW-1:0] base_slot, next_slot, scan_slot, rd_addr, wr_addr;
    logic [CW:0]   scan_sum, scan_c;
    logic          covered, qual, out_free, load_out, wr_en;
    logic [31:0]   stamp_age;
    logic [3:0]    ret_inc;
    logic [SW+2:0] slot_ext;
    logic [CW-1:0] base_inc, next_inc;

    always_comb begin
        if (r_next >= r_base) begin
            inuse_w = {1'b0, r_next} - {1'b0, r_base};
        end else begin
            inuse_w = {1'b0, r_next} + MOD2 - {1'b0, r_base};
        end
        inuse = inuse_w[CW-1:0];
        full  = (inuse >= WC);
        empty = (inuse == '0);

        unacked    = r_sent - r_acked;
        credit_now = ({1'b0, unacked} + {17'b0, r_plen}) <= {17'b0, r_win};

        base_c    = (r_base >= WC) ? r_base - WC : r_base;
        next_c    = (r_next >= WC) ? r_next - WC : r_next;
        base_slot = base_c[SW-1:0];
        next_slot = next_c[SW-1:0];
        scan_sum  = {1'b0, base_c} + {1'b0, r_idx};
        scan_c    = (scan_sum >= {1'b0, WC}) ? scan_sum - {1'b0, WC} : scan_sum;
        scan_slot = scan_c[SW-1:0];
        rd_addr   = i_ctrl.ack_rd ? base_slot : scan_slot;

        base_inc = (r_base == CMAX) ? '0 : r_base + 1'b1;
        next_inc = (r_next == CMAX) ? '0 : r_next + 1'b1;

        covered   = ({1'b0, r_rd_seq} + {17'b0, r_rd_len}) <= {1'b0, r_ack};
        stamp_age = r_clk - r_rd_stamp;
        qual      = (r_rd_ret < r_cfg_lim) && (stamp_age >= {16'b0, r_cfg_to});
        ret_inc   = r_rd_ret + 4'd1;

        out_free = !o_valid || !i_stall;
        load_out = i_ctrl.flush || (i_ctrl.tick_hit && r_pend_v);
        wr_en    = (i_ctrl.send_do && !full) || i_ctrl.tick_hit;
        wr_addr  = i_ctrl.send_do ? next_slot : r_rd_slot;
        slot_ext = {3'b0, r_pend_slot};

        o_stat.cmd       = i_command;
        o_stat.empty     = empty;
        o_stat.covered   = covered;
        o_stat.scan_more = (r_idx < inuse) && (r_n < swarq_pkg::MAX_RETX);
        o_stat.qual      = qual;
        o_stat.pend_v    = r_pend_v;
        o_stat.out_free  = out_free;
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_stamp[wr_addr] <= r_clk;
            mem_ret[wr_addr]   <= i_ctrl.send_do ? 4'd0 : ret_inc;
            if (i_ctrl.send_do) begin
                mem_seq[wr_addr] <= r_pseq;
                mem_len[wr_addr] <= r_plen;
            end
        end
        if (i_ctrl.ack_rd || i_ctrl.tick_rd) begin
            r_rd_seq   <= mem_seq[rd_addr];
            r_rd_len   <= mem_len[rd_addr];
            r_rd_stamp <= mem_stamp[rd_addr];
            r_rd_ret   <= mem_ret[rd_addr];
            r_rd_slot  <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_cmd  <= i_command;
            r_pseq <= i_packet_seq;
            r_plen <= i_packet_len;
            r_ack  <= i_ack_number;
            r_pwin <= i_peer_window;
        end
        if (i_ctrl.send_do) begin
            r_pend_kind   <= full ? swarq_pkg::KIND_SEND_REF : swarq_pkg::KIND_SEND_OK;
            r_pend_slot   <= full ? '0 : next_slot;
            r_pend_seq    <= full ? 32'd0 : r_pseq;
            r_pend_len    <= full ? 16'd0 : r_plen;
            r_pend_ret    <= 4'd0;
            r_pend_credit <= credit_now;
        end else if (i_ctrl.tick_hit) begin
            r_pend_kind <= swarq_pkg::KIND_RETX;
            r_pend_slot <= r_rd_slot;
            r_pend_seq  <= r_rd_seq;
            r_pend_len  <= r_rd_len;
            r_pend_ret  <= ret_inc;
        end else if (i_ctrl.ack_end || (i_ctrl.tick_end && !r_pend_v)) begin
            r_pend_kind <= i_ctrl.ack_end ? swarq_pkg::KIND_ACK_DONE
                                          : swarq_pkg::KIND_TICK_NONE;
            r_pend_slot <= '0;
            r_pend_seq  <= 32'd0;
            r_pend_len  <= 16'd0;
            r_pend_ret  <= 4'd0;
        end
        if (!i_rst_n || i_ctrl.tick_init) begin
            r_idx <= '0;
            r_n   <= 4'd0;
        end else if (i_ctrl.tick_skip) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_ctrl.tick_hit) begin
            r_idx <= r_idx + 1'b1;
            r_n   <= r_n + 4'd1;
        end
        if (load_out) begin
            o_kind          <= r_pend_kind;
            o_slot          <= slot_ext[2:0];
            o_out_seq       <= r_pend_seq;
            o_out_len       <= r_pend_len;
            o_credit_ok     <= (r_cmd == swarq_pkg::CMD_SEND) ? r_pend_credit : credit_now;
            o_unacked_bytes <= unacked;
            o_acked_upto    <= r_acked;
            o_window_now    <= r_win;
            o_outstanding   <= !empty;
            o_retries_done  <= r_pend_ret;
            o_last          <= i_ctrl.flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_to  <= 16'd500;
            r_cfg_lim <= 4'd5;
            r_sent    <= 32'd0;
            r_acked   <= 32'd0;
            r_win     <= 16'hFFFF;
            r_base    <= '0;
            r_next    <= '0;
            r_clk     <= 32'd0;
            r_pend_v  <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            if (i_ctrl.send_do && !full) begin
                r_sent <= r_sent + {16'b0, r_plen};
                r_next <= next_inc;
            end
            if (i_ctrl.ack_retire) begin
                r_base <= base_inc;
            end
            if (i_ctrl.ack_end) begin
                if (r_ack > r_acked) begin
                    r_acked <= r_ack;
                end
                r_win <= r_pwin;
            end
            if (i_ctrl.tick_init) begin
                r_clk <= r_clk + 32'd1;
            end
            if (i_ctrl.send_do || i_ctrl.ack_end || i_ctrl.tick_end || i_ctrl.tick_hit) begin
                r_pend_v <= 1'b1;
            end else if (i_ctrl.flush) begin
                r_pend_v <= 1'b0;
            end
            if (load_out) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    swarq_pkg::CFG_INIT_SEQ: begin
                        r_sent    <= i_cfg_data;
                        r_acked   <= i_cfg_data;
                    end
                    swarq_pkg::CFG_TIMEOUT:   r_cfg_to  <= i_cfg_data[15:0];
                    swarq_pkg::CFG_RETRY_LIM: r_cfg_lim <= i_cfg_data[3:0];
                    swarq_pkg::CFG_INIT_WIN: begin
                        r_win     <= i_cfg_data[15:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    `SWARQ_ASSERT_ALWAYS(a_inuse_bound, i_clk, i_rst_n, inuse <= WC)
    `SWARQ_ASSERT_ALWAYS(a_retx_cap, i_clk, i_rst_n, r_n <= swarq_pkg::MAX_RETX)
    `SWARQ_ASSERT_ALWAYS(a_nonlast_is_retx, i_clk, i_rst_n,
        !o_valid || o_last || (o_kind == swarq_pkg::KIND_RETX))
    `SWARQ_ASSERT_NEXT(a_tick_clock, i_clk, i_rst_n, i_ctrl.tick_init && !i_cfg_we,
        r_clk == $past(r_clk) + 32'd1)

endmodule

@@ hdl/sliding_window_arq_sender_core.sv @@
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_command, i_packet_seq, i_packet_len,
//                                           i_ack_number, i_peer_window
// result    out        o_valid / i_stall    o_kind .. o_last (eleven fields)
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item is worked on at a time; o_stall is low only while the controller idles.
// A send stores the packet in the next slot, or is refused while the window is full.
// An ack reads and retires slots from the window base until one is not covered, and
// a tick scans the slots in use for retransmits, one registered read per slot.
// Reset (synchronous, active low) loads the register defaults and empties the window.
// A stalled output holds the tick scan at the next retransmit found until it drains.
module sliding_window_arq_sender_core #(
    parameter int WINDOW_SLOTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_packet_seq,
    input  logic [15:0] i_packet_len,
    input  logic [31:0] i_ack_number,
    input  logic [15:0] i_peer_window,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_slot,
    output logic [31:0] o_out_seq,
    output logic [15:0] o_out_len,
    output logic        o_credit_ok,
    output logic [31:0] o_unacked_bytes,
    output logic [31:0] o_acked_upto,
    output logic [15:0] o_window_now,
    output logic        o_outstanding,
    output logic [3:0]  o_retries_done,
    output logic        o_last
);

    swarq_pkg::t_ctrl ctrl;
    swarq_pkg::t_stat stat;

    // The controller sequences each item; the datapath holds the window state,
    // the slot memory and the output register.
    swarq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    swarq_datapath #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_command       (i_command),
        .i_packet_seq    (i_packet_seq),
        .i_packet_len    (i_packet_len),
        .i_ack_number    (i_ack_number),
        .i_peer_window   (i_peer_window),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_slot          (o_slot),
        .o_out_seq       (o_out_seq),
        .o_out_len       (o_out_len),
        .o_credit_ok     (o_credit_ok),
        .o_unacked_bytes (o_unacked_bytes),
        .o_acked_upto    (o_acked_upto),
        .o_window_now    (o_window_now),
        .o_outstanding   (o_outstanding),
        .o_retries_done  (o_retries_done),
        .o_last          (o_last)
    );

    // New items are taken only while the controller is idle.
    assign o_stall = !ctrl.idle;

endmodule
